@@ design/afr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afr_pkg
// Shared constants and types of the addressed frame receiver.
// ----------------------------------------------------------------------------
package afr_pkg;

  // default number of payload bytes kept per frame
  localparam int unsigned PayloadCapacity = 16;

  // frame start marker and header length
  localparam logic [7:0] START_BYTE = 8'h3A;
  localparam int unsigned HeaderLen = 4;

  // input item opcodes
  localparam logic OP_LINE = 1'b0;
  localparam logic OP_ARM  = 1'b1;

  // frame completion notice from the receive side
  typedef struct packed {
    logic       valid;
    logic [7:0] count;
  } done_t;

  // header bytes as kept by the receive side
  typedef logic [HeaderLen-1:0][7:0] header_t;

endpackage

@@ design/addressed_frame_receiver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// addressed_frame_receiver
// Serial-bus frame receiver with address filter and buffered frame replay.
// ----------------------------------------------------------------------------
// Sequence: the frame end beat starts a burst of 4 + min(count,
//   PayloadCapacity) output beats, each a payload memory read state,
//   then an output beat state that holds while the output stalls.
// Throughput: one input beat per cycle; input stalls for the whole burst,
//   set by the emission sequencer and the single payload read port.
// Reset: asynchronous active low; clears phase, index, expected address and
//   the emitter; header and payload stores are not cleared.
// ----------------------------------------------------------------------------
module addressed_frame_receiver #(
  parameter int unsigned PayloadCapacity = afr_pkg::PayloadCapacity
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       opcode_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  output logic       truncated_o
);

  import afr_pkg::*;

  localparam int unsigned AddrW = (PayloadCapacity > 1) ? $clog2(PayloadCapacity) : 1;

  logic             accept;
  logic             busy;
  header_t          header;
  done_t            done;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [7:0]       wdata;
  logic             re;
  logic [AddrW-1:0] raddr;
  logic [7:0]       rdata;

  // input beat handshake
  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  afr_rx_ctrl #(
    .Capacity (PayloadCapacity),
    .AddrW    (AddrW)
  ) u_rx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .opcode_i    (opcode_i),
    .data_byte_i (data_byte_i),
    .header_o    (header),
    .done_o      (done),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata)
  );

  afr_payload_ram #(
    .Depth (PayloadCapacity),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  afr_emit_seq #(
    .Capacity (PayloadCapacity),
    .AddrW    (AddrW)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .done_i      (done),
    .header_i    (header),
    .rdata_i     (rdata),
    .re_o        (re),
    .raddr_o     (raddr),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .truncated_o (truncated_o)
  );

  // output beats only while input is held off
  a_emit_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("output beat while input open");

  // burst ends after the last beat is taken
  a_last_ends_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_o) |=> !out_valid_o && !in_stall_o)
    else $error("burst continues after last beat");

  // truncation flag constant within a burst
  a_trunc_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |=> truncated_o == $past(truncated_o))
    else $error("truncation flag changed within burst");

endmodule

@@ design/afr_payload_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afr_payload_ram
// Payload store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module afr_payload_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/afr_rx_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afr_rx_ctrl
// Receive sequencer: frame start, header capture, address match, payload store.
// ----------------------------------------------------------------------------
module afr_rx_ctrl #(
  parameter int unsigned Capacity = afr_pkg::PayloadCapacity,
  parameter int unsigned AddrW    = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             opcode_i,
  input  logic [7:0]       data_byte_i,
  output afr_pkg::header_t header_o,
  output afr_pkg::done_t   done_o,
  output logic             we_o,
  output logic [AddrW-1:0] waddr_o,
  output logic [7:0]       wdata_o
);

  import afr_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HDR  = 2'd1;
  localparam logic [1:0] PH_PAY  = 2'd2;

  localparam logic [8:0] CapW = 9'(Capacity);
  localparam logic [7:0] LastHdr = 8'(HeaderLen - 1);

  logic [1:0] phase_q, phase_d;
  logic [7:0] idx_q, idx_d;
  logic [7:0] exp_q, exp_d;
  header_t    hdr_q, hdr_d;
  logic       complete;
  logic       we;

  // frame sequencer
  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    exp_d    = exp_q;
    hdr_d    = hdr_q;
    complete = 1'b0;
    we       = 1'b0;
    if (accept_i) begin
      if (opcode_i == OP_ARM) begin
        exp_d = data_byte_i;
      end else begin
        unique case (phase_q)
          PH_PAY: begin
            if (idx_q < hdr_q[HeaderLen-1]) begin
              we    = ({1'b0, idx_q} < CapW);
              idx_d = idx_q + 8'd1;
            end else begin
              phase_d  = PH_IDLE;
              complete = 1'b1;
            end
          end
          PH_HDR: begin
            if (data_byte_i != START_BYTE) begin
              hdr_d[idx_q[1:0]] = data_byte_i;
              if (idx_q == LastHdr) begin
                idx_d = 8'd0;
                if (hdr_q[0] == exp_q) begin
                  exp_d   = 8'd0;
                  phase_d = PH_PAY;
                end else begin
                  phase_d = PH_IDLE;
                end
              end else begin
                idx_d = idx_q + 8'd1;
              end
            end
          end
          default: begin
            if (data_byte_i == START_BYTE) begin
              phase_d = PH_HDR;
              idx_d   = 8'd0;
            end
          end
        endcase
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      idx_q   <= 8'd0;
      exp_q   <= 8'd0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      exp_q   <= exp_d;
    end
  end

  // header bytes
  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
  end

  assign header_o     = hdr_q;
  assign done_o.valid = complete;
  assign done_o.count = hdr_q[HeaderLen-1];
  assign we_o         = we;
  assign waddr_o      = idx_q[AddrW-1:0];
  assign wdata_o      = data_byte_i;

endmodule

@@ design/afr_emit_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afr_emit_seq
// Emission sequencer: steps through header then stored payload, one beat each.
// ----------------------------------------------------------------------------
module afr_emit_seq #(
  parameter int unsigned Capacity = afr_pkg::PayloadCapacity,
  parameter int unsigned AddrW    = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  afr_pkg::done_t   done_i,
  input  afr_pkg::header_t header_i,
  input  logic [7:0]       rdata_i,
  output logic             re_o,
  output logic [AddrW-1:0] raddr_o,
  output logic             busy_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             last_o,
  output logic             truncated_o
);

  import afr_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_SHOW = 2'd2;

  localparam logic [8:0] CapW = 9'(Capacity);
  localparam logic [8:0] HdrW = 9'(HeaderLen);

  logic [1:0] st_q, st_d;
  logic [8:0] k_q, k_d;
  logic [8:0] total_q, total_d;
  logic       trunc_q, trunc_d;
  logic       trunc_new;
  logic [8:0] n_new;
  logic [8:0] k_next;
  logic       is_last;

  // payload length and truncation for a finished frame
  assign trunc_new = ({1'b0, done_i.count} > CapW);
  assign n_new     = trunc_new ? CapW : {1'b0, done_i.count};
  assign k_next    = k_q + 9'd1;
  assign is_last   = (k_next == total_q);

  // beat sequencer
  always_comb begin
    st_d    = st_q;
    k_d     = k_q;
    total_d = total_q;
    trunc_d = trunc_q;
    unique case (st_q)
      ST_READ: st_d = ST_SHOW;
      ST_SHOW: begin
        if (!out_stall_i) begin
          if (is_last) begin
            st_d = ST_IDLE;
          end else begin
            k_d  = k_next;
            st_d = ST_READ;
          end
        end
      end
      default: begin
        if (done_i.valid) begin
          k_d     = 9'd0;
          total_d = HdrW + n_new;
          trunc_d = trunc_new;
          st_d    = ST_READ;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      k_q     <= 9'd0;
      total_q <= 9'd0;
      trunc_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      k_q     <= k_d;
      total_q <= total_d;
      trunc_q <= trunc_d;
    end
  end

  // payload read address runs behind the header
  logic [8:0] paddr;
  assign paddr   = k_q - HdrW;
  assign re_o    = (st_q == ST_READ);
  assign raddr_o = paddr[AddrW-1:0];

  assign busy_o      = (st_q != ST_IDLE);
  assign out_valid_o = (st_q == ST_SHOW);
  assign out_byte_o  = (k_q < HdrW) ? header_i[k_q[1:0]] : rdata_i;
  assign last_o      = is_last;
  assign truncated_o = trunc_q;

endmodule
